// ===== src/sfed_pkg.sv =====
// ----------------------------------------------------------------------------
// sfed_pkg: shared types and constants of the SYN flood EWMA detector
// Widths, fixed-point sizes, status codes and register indexes.
// ----------------------------------------------------------------------------
package sfed_pkg;

   // counter and fixed-point sizing
   localparam int COUNT_WIDTH   = 24;
   localparam int FRACTION_BITS = 8;

   localparam int WEIGHT_W = 9;    // beta, Q1.8, values above 256 act as 256
   localparam int ALPHA_W  = 12;   // alpha, Q4.8
   localparam int LIMIT_W  = 8;
   localparam int AVG_W    = 32;
   localparam int RUN_W    = 8;
   localparam int TICK_W   = 16;
   localparam int REPORT_COUNT_W = 24;

   localparam int SCALED_W = COUNT_WIDTH + FRACTION_BITS;
   localparam int PROD_W   = WEIGHT_W + ((SCALED_W > AVG_W) ? SCALED_W : AVG_W);
   localparam int SUM_W    = PROD_W + 1;
   localparam int NEXT_W   = SUM_W - 8;
   localparam int GAIN_W   = ALPHA_W + 1;             // 256 + alpha
   localparam int LHS_W    = SCALED_W + 8;
   localparam int RHS_W    = GAIN_W + AVG_W;
   localparam int CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   localparam logic [WEIGHT_W-1:0]    Q8_ONE    = WEIGHT_W'(256);
   localparam logic [AVG_W-1:0]       AVG_RESET = AVG_W'(64'd100 << FRACTION_BITS);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [RUN_W-1:0]       RUN_MAX   = {RUN_W{1'b1}};
   localparam logic [TICK_W-1:0]      TICK_MAX  = {TICK_W{1'b1}};

   localparam logic [WEIGHT_W-1:0] BETA_RESET  = WEIGHT_W'(230);
   localparam logic [ALPHA_W-1:0]  ALPHA_RESET = ALPHA_W'(128);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(3);

   // result status codes
   localparam logic [1:0] STATUS_PASS  = 2'd0;
   localparam logic [1:0] STATUS_OK    = 2'd1;
   localparam logic [1:0] STATUS_FLOOD = 2'd2;

   // input kinds carried on req_tuser
   localparam logic ACTION_PACKET = 1'b0;
   localparam logic ACTION_TICK   = 1'b1;

   // register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_BETA  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT = 2'd2;

   localparam int RSP_DATA_W = 88;

endpackage

// ===== src/syn_flood_ewma_detector_unit.sv =====
// ----------------------------------------------------------------------------
// syn_flood_ewma_detector_unit: SYN flood detector with adaptive threshold
// Counts SYN packets per interval; each tick folds the count into an EWMA,
// compares against (1+alpha) times the old average and reports a status.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                            | payload
//  --------+-----------+----------------------------------+------------------------
//  req     | in        | req_tvalid/tready/tdata/tuser    | tuser: action
//          |           |                                  | tdata: syn_flag [0]
//  rsp     | out       | rsp_tvalid/tready/tdata          | status, interval_count,
//          |           |                                  | smoothed_rate, over_thr,
//          |           |                                  | consecutive, index
//  csr     | in        | csr_valid/ready/index/data       | register writes
//
//  Timing: an input transfer lands in the input register; from there the
//  item is processed against the state and, for a tick, the result register
//  is loaded. One item per cycle is sustained while no tick waits on the
//  rsp side. A packet event never waits on the rsp side.
//  A tick waits in the input register only while the result register holds
//  an untaken result. Reset (synchronous) restores config, state and valid flags.
//  csr_ready is always high.
//
module syn_flood_ewma_detector_unit (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] syn_flag, [7:1] zero
   input  logic        req_tuser,    // [0] action
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [sfed_pkg::RSP_DATA_W-1:0] rsp_tdata,
      // [1:0] status, [25:2] interval_count, [57:26] smoothed_rate,
      // [58] over_threshold, [66:59] consecutive_count,
      // [82:67] interval_index, [87:83] zero
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [sfed_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfed_pkg::CSR_DATA_W-1:0]  csr_data
);

   // configuration registers
   logic [sfed_pkg::WEIGHT_W-1:0] beta_ff;
   logic [sfed_pkg::ALPHA_W-1:0]  alpha_ff;
   logic [sfed_pkg::LIMIT_W-1:0]  limit_ff;

   // input register
   logic in_valid_ff;
   logic in_action_ff;
   logic in_syn_ff;

   // detector state
   logic [sfed_pkg::COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic [sfed_pkg::AVG_W-1:0]       avg_ff, avg_in;
   logic [sfed_pkg::RUN_W-1:0]       run_ff, run_in;
   logic [sfed_pkg::TICK_W-1:0]      tick_ff, tick_in;

   // result register
   logic                            out_valid_ff;
   logic [sfed_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic in_take, stage_go, is_tick;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff  <= sfed_pkg::BETA_RESET;
         alpha_ff <= sfed_pkg::ALPHA_RESET;
         limit_ff <= sfed_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sfed_pkg::CSR_BETA:  beta_ff  <= csr_data[sfed_pkg::WEIGHT_W-1:0];
            sfed_pkg::CSR_ALPHA: alpha_ff <= csr_data[sfed_pkg::ALPHA_W-1:0];
            sfed_pkg::CSR_LIMIT: limit_ff <= csr_data[sfed_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- handshake ----
   assign is_tick    = (in_action_ff == sfed_pkg::ACTION_TICK);
   // packets always drain; a tick drains when the result slot frees up
   assign stage_go   = in_valid_ff && (!is_tick || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || stage_go;
   assign in_take    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_action_ff <= req_tuser;
         in_syn_ff    <= req_tdata[0];
      end
   end

   // ---- tick arithmetic ----
   logic [sfed_pkg::WEIGHT_W-1:0] beta_eff, beta_inv;
   logic [sfed_pkg::SCALED_W-1:0] scaled_count;
   logic [sfed_pkg::PROD_W-1:0]   prod_old, prod_new;
   logic [sfed_pkg::SUM_W-1:0]    ewma_sum;
   logic [sfed_pkg::NEXT_W-1:0]   ewma_next;
   logic [sfed_pkg::AVG_W-1:0]    ewma_sat;
   logic [sfed_pkg::GAIN_W-1:0]   gain;
   logic [sfed_pkg::CMP_W-1:0]    lhs, rhs;
   logic                          over_thr;
   logic [1:0]                    status;
   logic [sfed_pkg::TICK_W:0]     tick_plus;

   always_comb begin
      // beta above one acts as one
      beta_eff     = (beta_ff > sfed_pkg::Q8_ONE) ? sfed_pkg::Q8_ONE : beta_ff;
      beta_inv     = sfed_pkg::Q8_ONE - beta_eff;
      scaled_count = {counter_ff, {sfed_pkg::FRACTION_BITS{1'b0}}};
      prod_old     = sfed_pkg::PROD_W'(beta_eff) * sfed_pkg::PROD_W'(avg_ff);
      prod_new     = sfed_pkg::PROD_W'(beta_inv) * sfed_pkg::PROD_W'(scaled_count);
      ewma_sum     = sfed_pkg::SUM_W'(prod_old) + sfed_pkg::SUM_W'(prod_new);
      ewma_next    = ewma_sum[sfed_pkg::SUM_W-1:8];
      ewma_sat     = (|ewma_next[sfed_pkg::NEXT_W-1:sfed_pkg::AVG_W]) ?
                     {sfed_pkg::AVG_W{1'b1}} : ewma_next[sfed_pkg::AVG_W-1:0];

      // exact compare: count << (F+8) >= (256 + alpha) * old average
      gain     = sfed_pkg::GAIN_W'(alpha_ff) + sfed_pkg::GAIN_W'(sfed_pkg::Q8_ONE);
      lhs      = sfed_pkg::CMP_W'({scaled_count, 8'd0});
      rhs      = sfed_pkg::CMP_W'(sfed_pkg::CMP_W'(gain) * sfed_pkg::CMP_W'(avg_ff));
      over_thr = (lhs >= rhs);

      if (over_thr) begin
         run_in = (run_ff == sfed_pkg::RUN_MAX) ? run_ff : run_ff + 1'b1;
      end else begin
         run_in = '0;
      end
      tick_in   = (tick_ff == sfed_pkg::TICK_MAX) ? tick_ff : tick_ff + 1'b1;
      tick_plus = {1'b0, tick_in} + 1'b1;

      // warm-up while the tick index plus one is below run_limit
      if (tick_plus < (sfed_pkg::TICK_W+1)'(limit_ff)) begin
         status = sfed_pkg::STATUS_PASS;
      end else if (run_in >= limit_ff) begin
         status = sfed_pkg::STATUS_FLOOD;
      end else begin
         status = sfed_pkg::STATUS_OK;
      end

      avg_in = ewma_sat;
      if (is_tick) begin
         counter_in = '0;
      end else if (in_syn_ff && counter_ff != sfed_pkg::COUNT_MAX) begin
         counter_in = counter_ff + 1'b1;
      end else begin
         counter_in = counter_ff;
      end

      out_data_in = {5'd0, tick_in, run_in, over_thr, ewma_sat,
                     sfed_pkg::REPORT_COUNT_W'(counter_ff), status};
   end

   // ---- state and result registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         avg_ff     <= sfed_pkg::AVG_RESET;
         run_ff     <= '0;
         tick_ff    <= '0;
      end else if (stage_go) begin
         counter_ff <= counter_in;
         if (is_tick) begin
            avg_ff  <= avg_in;
            run_ff  <= run_in;
            tick_ff <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_go && is_tick) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_go && is_tick) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== src/sfed_port_checker.sv =====
// ----------------------------------------------------------------------------
// sfed_port_checker: port-level assertions for the detector
// Watches the result stream for stall behavior and field consistency.
// ----------------------------------------------------------------------------
module sfed_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [sfed_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == sfed_pkg::STATUS_PASS ||
                      rsp_tdata[1:0] == sfed_pkg::STATUS_OK ||
                      rsp_tdata[1:0] == sfed_pkg::STATUS_FLOOD))
      else $error("invalid status code");

   // run is zero exactly when the interval did not signal
   a_run_follows_signal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[58] == (rsp_tdata[66:59] != 8'd0)))
      else $error("consecutive count disagrees with over_threshold");

   a_index_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[82:67] != 16'd0)
      else $error("result with zero interval index");

endmodule

bind syn_flood_ewma_detector_unit sfed_port_checker u_sfed_port_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_syn_flood_ewma_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_syn_flood_ewma_detector_unit: self-checking bench for the SYN flood unit
// Streams packet events and interval ticks through the req channel and
// predicts each tick's report (EWMA, threshold signal, run, status) in the
// bench itself. Each rsp transfer is checked field by field. Register writes
// happen only while the unit is drained. Both sides idle at random and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_syn_flood_ewma_detector_unit;

   localparam int   HALF_PERIOD    = 6;
   localparam int   RESET_CYCLES   = 10;
   localparam int   SETTLE_CYCLES  = 4;     // input reg + process stage, with margin
   localparam int   WATCHDOG_LIMIT = 2000;  // cycles without any transfer
   localparam int   HOLD_CYCLES    = 120;   // long receiver back-pressure
   localparam int   TOTAL_ITEMS    = 950;
   localparam logic [sfed_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;  // unmapped index

   typedef struct packed {
      logic action;
      logic syn;
   } net_event_type;

   typedef struct packed {
      logic [1:0]                          status;
      logic [sfed_pkg::REPORT_COUNT_W-1:0] count;
      logic [sfed_pkg::AVG_W-1:0]          rate;
      logic                                over;
      logic [sfed_pkg::RUN_W-1:0]          run;
      logic [sfed_pkg::TICK_W-1:0]         index;
   } alert_report_type;

   // DUT signals; the bench-driven ones are known from time zero
   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata  = '0;   // [0] syn_flag, [7:1] zero
   logic                             req_tuser  = 1'b0; // [0] action
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [sfed_pkg::RSP_DATA_W-1:0]  rsp_tdata;
      // [1:0] status, [25:2] interval_count, [57:26] smoothed_rate,
      // [58] over_threshold, [66:59] consecutive_count, [82:67] interval_index
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [sfed_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [sfed_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   // stimulus and scoreboard
   net_event_type    ingress_items[$];
   alert_report_type expected_reports[$];
   net_event_type    req_event_live;
   int unsigned   events_queued   = 0;
   int unsigned   events_taken    = 0;
   int unsigned   mismatch_count  = 0;
   int unsigned   quiet_cycles    = 0;
   int unsigned   gap_pct         = 36;
   logic          rsp_hold_arm    = 1'b0;
   logic          rsp_hold_done   = 1'b0;
   int unsigned   rsp_hold_left   = 0;

   // predictor copy of configuration and state
   logic [sfed_pkg::WEIGHT_W-1:0]    cfg_beta     = sfed_pkg::BETA_RESET;
   logic [sfed_pkg::ALPHA_W-1:0]     cfg_alpha    = sfed_pkg::ALPHA_RESET;
   logic [sfed_pkg::LIMIT_W-1:0]     cfg_limit    = sfed_pkg::LIMIT_RESET;
   logic [sfed_pkg::COUNT_WIDTH-1:0] syn_tally    = '0;
   logic [sfed_pkg::AVG_W-1:0]       avg_q8       = sfed_pkg::AVG_RESET;
   logic [sfed_pkg::RUN_W-1:0]       alarm_streak = '0;
   logic [sfed_pkg::TICK_W-1:0]      tick_num     = '0;

   syn_flood_ewma_detector_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
   endtask

   // Advance the detector by one accepted event; a tick queues its report.
   task automatic detector_step(net_event_type ev);
      logic [63:0]      weight;
      logic [63:0]      prev;
      logic [63:0]      blend;
      logic [63:0]      next_avg;
      logic [63:0]      lhs;
      logic [63:0]      rhs;
      alert_report_type rep;
      if (ev.action == sfed_pkg::ACTION_PACKET) begin
         // non-SYN packets leave everything alone; the counter sticks at full
         if (ev.syn && syn_tally != sfed_pkg::COUNT_MAX)
            syn_tally++;
         return;
      end
      if (tick_num != sfed_pkg::TICK_MAX)
         tick_num++;
      // beta above one is clamped, so the average holds
      weight   = (64'(cfg_beta) > 64'(sfed_pkg::Q8_ONE)) ? 64'(sfed_pkg::Q8_ONE)
                                                          : 64'(cfg_beta);
      prev     = 64'(avg_q8);
      blend    = weight * prev
               + (64'(sfed_pkg::Q8_ONE) - weight)
                 * (64'(syn_tally) << sfed_pkg::FRACTION_BITS);
      next_avg = blend >> 8;
      if (next_avg > 64'hFFFF_FFFF)
         next_avg = 64'hFFFF_FFFF;
      // exact compare: count vs (1 + alpha) * old average
      lhs = 64'(syn_tally) << (sfed_pkg::FRACTION_BITS + 8);
      rhs = (64'(sfed_pkg::Q8_ONE) + 64'(cfg_alpha)) * prev;
      rep.over  = (lhs >= rhs);
      rep.count = sfed_pkg::REPORT_COUNT_W'(syn_tally);
      rep.rate  = next_avg[sfed_pkg::AVG_W-1:0];
      syn_tally = '0;
      avg_q8    = next_avg[sfed_pkg::AVG_W-1:0];
      if (rep.over) begin
         if (alarm_streak != sfed_pkg::RUN_MAX)
            alarm_streak++;
      end else begin
         alarm_streak = '0;
      end
      if (int'(tick_num) + 1 < int'(cfg_limit))
         rep.status = sfed_pkg::STATUS_PASS;
      else if (alarm_streak >= cfg_limit)
         rep.status = sfed_pkg::STATUS_FLOOD;
      else
         rep.status = sfed_pkg::STATUS_OK;
      rep.run   = alarm_streak;
      rep.index = tick_num;
      expected_reports.push_back(rep);
   endtask

   // Driver: offers queued events, predicts on each req transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            detector_step(req_event_live);
            events_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (ingress_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
               req_event_live = ingress_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= req_event_live.action;
               req_tdata  <= {7'b0, req_event_live.syn};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random ready, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (rsp_hold_arm && !rsp_hold_done) begin
         rsp_hold_left <= HOLD_CYCLES;
         rsp_hold_done <= 1'b1;
         rsp_tready    <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= gap_pct);
      end
   end

   // Monitor: each rsp transfer against the oldest expected report.
   always @(posedge clock) begin
      alert_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            note_mismatch("report with none pending", 64'(rsp_tdata[82:0]), 64'd0);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               note_mismatch("status", 64'(rsp_tdata[1:0]), 64'(want.status));
            if (rsp_tdata[25:2] !== want.count)
               note_mismatch("interval_count", 64'(rsp_tdata[25:2]), 64'(want.count));
            if (rsp_tdata[57:26] !== want.rate)
               note_mismatch("smoothed_rate", 64'(rsp_tdata[57:26]), 64'(want.rate));
            if (rsp_tdata[58] !== want.over)
               note_mismatch("over_threshold", 64'(rsp_tdata[58]), 64'(want.over));
            if (rsp_tdata[66:59] !== want.run)
               note_mismatch("consecutive_count", 64'(rsp_tdata[66:59]), 64'(want.run));
            if (rsp_tdata[82:67] !== want.index)
               note_mismatch("interval_index", 64'(rsp_tdata[82:67]), 64'(want.index));
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("FAIL syn_flood_ewma_detector_unit");
      $finish;
   end

   task automatic push_event(logic action, logic syn);
      net_event_type ev;
      ev.action = action;
      ev.syn    = syn;
      ingress_items.push_back(ev);
      events_queued++;
   endtask

   // One interval: SYN and non-SYN packets shuffled, closed by a tick.
   task automatic push_interval(int unsigned n_syn, int unsigned n_noise);
      while (n_syn + n_noise != 0) begin
         if (n_noise == 0 || (n_syn != 0 && $urandom_range(n_syn + n_noise - 1) < n_syn)) begin
            push_event(sfed_pkg::ACTION_PACKET, 1'b1);
            n_syn--;
         end else begin
            push_event(sfed_pkg::ACTION_PACKET, 1'b0);
            n_noise--;
         end
      end
      push_event(sfed_pkg::ACTION_TICK, 1'($urandom));   // syn bit is don't-care on a tick
   endtask

   // Wait until every event is taken and every report has come back,
   // then let the pipeline settle (a trailing packet yields no report).
   task automatic drain();
      while (events_taken != events_queued || expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Valid stays up across back-to-back writes; caller drops it.
   task automatic write_reg(logic [sfed_pkg::CSR_INDEX_W-1:0] idx,
                            logic [sfed_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         sfed_pkg::CSR_BETA:  cfg_beta  = data[sfed_pkg::WEIGHT_W-1:0];
         sfed_pkg::CSR_ALPHA: cfg_alpha = data[sfed_pkg::ALPHA_W-1:0];
         sfed_pkg::CSR_LIMIT: cfg_limit = data[sfed_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // Unused upper data bits are randomized; the unit keeps the low bits.
   task automatic reconfigure(logic [sfed_pkg::WEIGHT_W-1:0] beta,
                              logic [sfed_pkg::ALPHA_W-1:0] alpha,
                              logic [sfed_pkg::LIMIT_W-1:0] limit);
      write_reg(sfed_pkg::CSR_BETA,  {3'($urandom), beta});
      write_reg(sfed_pkg::CSR_ALPHA, alpha);
      write_reg(sfed_pkg::CSR_LIMIT, {4'($urandom), limit});
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned kind;
      int unsigned n_syn;
      logic [sfed_pkg::WEIGHT_W-1:0] beta;
      logic [sfed_pkg::ALPHA_W-1:0]  alpha;
      logic [sfed_pkg::LIMIT_W-1:0]  limit;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset configuration: ignored packet, a warm-up tick,
      // a tick with its syn bit set, then a small count past warm-up.
      push_event(sfed_pkg::ACTION_PACKET, 1'b0);
      push_event(sfed_pkg::ACTION_TICK,   1'b0);
      push_event(sfed_pkg::ACTION_TICK,   1'b1);
      push_interval(3, 1);
      drain();

      // Beta above one: the average must hold across ticks.
      reconfigure(9'd511, 12'd0, 8'd1);
      push_interval(0, 1);
      push_interval(2, 0);
      drain();

      // Zero run limit: no warm-up, every tick is a flood. Unmapped index too.
      reconfigure(9'd256, 12'd4095, 8'd0);
      write_reg(CSR_UNUSED, 12'hFFF);
      csr_valid <= 1'b0;
      push_interval(1, 0);
      push_event(sfed_pkg::ACTION_TICK, 1'b0);
      drain();

      // Run saturation: beta zero drives the average to zero, so every empty
      // interval signals. Long warm-up with limit 255, no idling on either
      // side, and one long receiver hold-off so the unit backs up.
      gap_pct = 0;
      reconfigure(9'd0, 12'd0, 8'd255);
      for (int i = 0; i < 270; i++) begin
         if (i % 37 == 0)
            push_event(sfed_pkg::ACTION_PACKET, 1'b0);
         push_event(sfed_pkg::ACTION_TICK, 1'($urandom));
      end
      rsp_hold_arm <= 1'b1;
      drain();
      gap_pct = 36;

      // Random phases: new settings each time, intervals mostly well-formed
      // with quiet, moderate and burst counts; some tick-only runs as noise.
      while (events_queued < TOTAL_ITEMS) begin
         case ($urandom_range(5))
            0:       beta = 9'd0;
            1:       beta = 9'd256;
            2:       beta = 9'($urandom_range(511, 257));
            default: beta = 9'($urandom_range(255));
         endcase
         case ($urandom_range(4))
            0:       alpha = 12'd0;
            1:       alpha = 12'd4095;
            default: alpha = 12'($urandom_range(600));
         endcase
         case ($urandom_range(7))
            0:       limit = 8'd255;
            1:       limit = 8'd0;
            default: limit = 8'($urandom_range(5, 1));
         endcase
         reconfigure(beta, alpha, limit);
         repeat ($urandom_range(16, 6)) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
               repeat ($urandom_range(4, 2))
                  push_event(sfed_pkg::ACTION_TICK, 1'($urandom));
            end else begin
               if (kind < 40)      n_syn = $urandom_range(2);
               else if (kind < 75) n_syn = $urandom_range(8, 2);
               else                n_syn = $urandom_range(40, 8);
               push_interval(n_syn, $urandom_range(3));
            end
         end
         drain();
      end

      if (mismatch_count == 0)
         $display("PASS syn_flood_ewma_detector_unit");
      else
         $display("FAIL syn_flood_ewma_detector_unit");
      $finish;
   end

endmodule
